FILE: rtl/hri_pkg.sv
`timescale 1ns / 1ps

package hri_pkg;

    // Operand alignment of the shared compare/subtract step
    typedef logic hri_mode_t;

    localparam hri_mode_t MODE_DIGIT = 1'b0;  // remainder step of a base digit
    localparam hri_mode_t MODE_FRAC  = 1'b1;  // quotient bit of the fraction

endpackage

FILE: rtl/hri_divstep.sv
`timescale 1ns / 1ps

module hri_divstep
    import hri_pkg::*;
#(
    parameter int WIDE_BITS  = 39,
    parameter int RADIX_BITS = 8
) (
    input  hri_mode_t              mode,
    input  logic [RADIX_BITS-1:0]  rem,
    input  logic                   bit_in,
    input  logic [RADIX_BITS-1:0]  base,
    input  logic [WIDE_BITS-1:0]   rev,
    input  logic [WIDE_BITS-1:0]   pw,
    output logic                   ge,
    output logic [WIDE_BITS:0]     diff
);

    localparam int SW = WIDE_BITS + 1;

    logic [SW-1:0] op_a;
    logic [SW-1:0] op_b;
    logic [SW:0]   diff_full;

    always_comb begin
        if (mode == MODE_DIGIT) begin
            op_a = SW'({rem, bit_in});
            op_b = SW'(base);
        end else begin
            op_a = {rev, 1'b0};
            op_b = {1'b0, pw};
        end
    end

    // borrow out of the top bit means op_a < op_b
    assign diff_full = {1'b0, op_a} - {1'b0, op_b};
    assign ge        = ~diff_full[SW];
    assign diff      = diff_full[SW-1:0];

endmodule

FILE: rtl/halton_radical_inverse_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Direction
// request   s_valid s_ready s_sample_index s_radix  in
// result    m_valid m_ready m_fraction m_bad_radix  out
//
// One request at a time. Per base digit of the index a request runs the ST_DIV
// loop, ST_MUL_R and ST_MUL_P; then ST_FRAC, then ST_DONE. A radix below 2 goes
// straight to ST_DONE. The digit loop and the fraction loop share one
// compare/subtract unit, one bit per cycle, and one multiplier for R and P.
// aresetn clears the sequencer and the result valid. The result register
// lets a new request enter while the previous result waits on m_ready.

module halton_radical_inverse_core
    import hri_pkg::*;
#(
    parameter int INDEX_BITS    = 31,
    parameter int FRACTION_BITS = 32,
    parameter int RADIX_BITS    = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [INDEX_BITS-1:0]    s_sample_index,
    input  logic [RADIX_BITS-1:0]    s_radix,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRACTION_BITS-1:0] m_fraction,
    output logic                     m_bad_radix
);

    localparam int W     = INDEX_BITS + RADIX_BITS;
    localparam int STEPS = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MUL_R = 3'd2;
    localparam logic [2:0] ST_MUL_P = 3'd3;
    localparam logic [2:0] ST_FRAC  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0]    idx_reg, idx_next;
    logic [RADIX_BITS-1:0]    base_reg, base_next;
    logic [RADIX_BITS-1:0]    rem_reg, rem_next;
    logic [W-1:0]             rev_reg, rev_next;
    logic [W-1:0]             pw_reg, pw_next;
    logic [FRACTION_BITS-1:0] q_reg, q_next;
    logic                     bad_reg, bad_next;
    logic                     m_valid_reg, m_valid_next;
    logic [FRACTION_BITS-1:0] m_fraction_reg, m_fraction_next;
    logic                     m_bad_radix_reg, m_bad_radix_next;

    hri_mode_t        mode;
    logic             ge;
    logic [W:0]       diff;
    logic [W-1:0]     mul_a;
    logic [W+RADIX_BITS-1:0] prod;

    assign mode = (state_reg == ST_FRAC) ? MODE_FRAC : MODE_DIGIT;

    hri_divstep #(
        .WIDE_BITS  (W),
        .RADIX_BITS (RADIX_BITS)
    ) u_divstep (
        .mode   (mode),
        .rem    (rem_reg),
        .bit_in (idx_reg[INDEX_BITS-1]),
        .base   (base_reg),
        .rev    (rev_reg),
        .pw     (pw_reg),
        .ge     (ge),
        .diff   (diff)
    );

    assign mul_a = (state_reg == ST_MUL_P) ? pw_reg : rev_reg;
    assign prod  = {{RADIX_BITS{1'b0}}, mul_a} * {{W{1'b0}}, base_reg};

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_fraction  = m_fraction_reg;
    assign m_bad_radix = m_bad_radix_reg;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        base_next        = base_reg;
        rem_next         = rem_reg;
        rev_next         = rev_reg;
        pw_next          = pw_reg;
        q_next           = q_reg;
        bad_next         = bad_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_fraction_next  = m_fraction_reg;
        m_bad_radix_next = m_bad_radix_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next  = s_sample_index;
                    base_next = s_radix;
                    rem_next  = '0;
                    rev_next  = '0;
                    pw_next   = W'(1);
                    q_next    = '0;
                    bad_next  = (s_radix < RADIX_BITS'(2));
                    cnt_next  = CW'(INDEX_BITS);
                    if (s_radix < RADIX_BITS'(2)) begin
                        state_next = ST_DONE;
                    end else if (s_sample_index == '0) begin
                        cnt_next   = CW'(FRACTION_BITS);
                        state_next = ST_FRAC;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // shift the quotient bit in as the index bit moves to the remainder
                idx_next = {idx_reg[INDEX_BITS-2:0], ge};
                rem_next = ge ? diff[RADIX_BITS-1:0]
                              : {rem_reg[RADIX_BITS-2:0], idx_reg[INDEX_BITS-1]};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                rev_next   = prod[W-1:0] + W'(rem_reg);
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                pw_next  = prod[W-1:0];
                rem_next = '0;
                if (idx_reg == '0) begin
                    cnt_next   = CW'(FRACTION_BITS);
                    state_next = ST_FRAC;
                end else begin
                    cnt_next   = CW'(INDEX_BITS);
                    state_next = ST_DIV;
                end
            end
            ST_FRAC: begin
                rev_next = ge ? diff[W-1:0] : {rev_reg[W-2:0], 1'b0};
                q_next   = {q_reg[FRACTION_BITS-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_fraction_next  = bad_reg ? '0 : q_reg;
                    m_bad_radix_next = bad_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        idx_reg         <= idx_next;
        base_reg        <= base_next;
        rem_reg         <= rem_next;
        rev_reg         <= rev_next;
        pw_reg          <= pw_next;
        q_reg           <= q_next;
        bad_reg         <= bad_next;
        m_fraction_reg  <= m_fraction_next;
        m_bad_radix_reg <= m_bad_radix_next;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int INDEX_BITS    = 31;
    localparam int FRACTION_BITS = 32;
    localparam int RADIX_BITS    = 8;
    localparam int IDLE_PCT      = 8;
    localparam int DRAIN_CYCLES  = 1100;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] fraction;
        logic                     bad_radix;
    } inverse_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [INDEX_BITS-1:0]    s_sample_index = '0;
    logic [RADIX_BITS-1:0]    s_radix = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [FRACTION_BITS-1:0] m_fraction;
    logic                     m_bad_radix;

    inverse_t expected_inverses[$];
    int       mismatches = 0;
    bit       no_idle = 1'b0;

    halton_radical_inverse_core #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .RADIX_BITS    (RADIX_BITS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .s_radix        (s_radix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fraction     (m_fraction),
        .m_bad_radix    (m_bad_radix)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror the base digits of the index, then divide exactly:
    // fraction = floor(R * 2^32 / P).
    function automatic inverse_t radical_inverse(input logic [INDEX_BITS-1:0] idx,
                                                 input logic [RADIX_BITS-1:0] radix);
        inverse_t               r;
        logic [63:0]            rev;
        logic [63:0]            pw;
        logic [INDEX_BITS-1:0]  n;
        logic [127:0]           num;
        r.fraction  = '0;
        r.bad_radix = 1'b0;
        if (radix < 2) begin
            r.bad_radix = 1'b1;
            return r;
        end
        rev = 64'd0;
        pw  = 64'd1;
        n   = idx;
        while (n != 0) begin
            rev = rev * radix + 64'(n % radix);
            pw  = pw * radix;
            n   = n / radix;
        end
        num = 128'(rev) << FRACTION_BITS;
        r.fraction = FRACTION_BITS'(num / 128'(pw));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [INDEX_BITS-1:0] idx,
                                input logic [RADIX_BITS-1:0] radix);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_index <= idx;
        s_radix        <= radix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_inverses.push_back(radical_inverse(idx, radix));
        @(negedge aclk);
    endtask

    function automatic logic [INDEX_BITS-1:0] random_index();
        int unsigned w;
        w = $urandom_range(0, INDEX_BITS);
        return INDEX_BITS'($urandom & ((64'd1 << w) - 1));
    endfunction

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_inverses.size() == 0) begin
                report_mismatch($sformatf("unexpected result fraction=%h bad_radix=%b",
                                          m_fraction, m_bad_radix));
            end else begin
                inverse_t want;
                want = expected_inverses.pop_front();
                if (m_fraction !== want.fraction)
                    report_mismatch($sformatf("fraction got %h want %h",
                                              m_fraction, want.fraction));
                if (m_bad_radix !== want.bad_radix)
                    report_mismatch($sformatf("bad_radix got %b want %b",
                                              m_bad_radix, want.bad_radix));
            end
        end
    end

    task automatic test_directed();
        send_request('0, 8'd2);
        send_request('0, 8'd255);
        send_request('0, 8'd0);
        send_request('1, 8'd0);
        send_request('1, 8'd1);
        send_request(31'h2AAA_AAAA, 8'd1);
        send_request('1, 8'd2);
        send_request('1, 8'd3);
        send_request('1, 8'd255);
        send_request('1, 8'd128);
        send_request(31'd1, 8'd2);
        send_request(31'd1, 8'd7);
        send_request(31'h4000_0000, 8'd2);
        send_request(31'd123456789, 8'd10);
        send_request(31'h7FFF_FFFE, 8'd16);
        send_request(31'd254, 8'd255);
        send_request(31'd255, 8'd255);
        send_request(31'd65025, 8'd255);
        send_request(31'h5555_5555, 8'd254);
        send_request(31'd127, 8'd128);
    endtask

    task automatic test_random_radix(input int count);
        logic [RADIX_BITS-1:0] radix;
        for (int i = 0; i < count; i++) begin
            // steer some requests onto the invalid bases
            if ($urandom_range(0, 99) < 6) radix = RADIX_BITS'($urandom_range(0, 1));
            else radix = RADIX_BITS'($urandom);
            send_request(random_index(), radix);
        end
    endtask

    task automatic test_small_radix(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_index(), RADIX_BITS'($urandom_range(2, 16)));
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(random_index(), RADIX_BITS'($urandom));
        no_idle = 1'b0;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge aclk);
        // hold so that any stray extra result shows up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_inverses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_inverses.size()));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_radix(280);
        test_small_radix(230);
        test_back_to_back(170);
        wait_drain();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
